### src/cbb_pkg.sv
// ----------------------------------------------------------------------------
// cbb_pkg: shared types, constants and coefficient table
// Types, default sizes and the band-pass coefficient set used by the cascaded
// biquad filter and its datapath modules.
// ----------------------------------------------------------------------------
package cbb_pkg;

   localparam int SAMPLE_W         = 16;
   localparam int SECTIONS_DEF     = 6;
   localparam int COEF_BITS_DEF    = 24;
   localparam int HISTORY_BITS_DEF = 32;
   localparam int ROM_ROWS         = 6;
   localparam int ROW_W            = $clog2(ROM_ROWS);
   localparam int COEF_SELS        = 4;

   // Coefficient of one row: b0, b2 (= -b0), a1, a2
   typedef enum logic [1:0] {
      COEF_B0,
      COEF_B2,
      COEF_A1,
      COEF_A2
   } coef_sel_type;

   // Product terms of one section, in issue order
   typedef enum logic [1:0] {
      TERM_X2,
      TERM_Y1,
      TERM_Y2,
      TERM_X
   } term_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DELIVER
   } state_type;

   // One issue slot of the shared multiply-accumulate unit
   typedef struct packed {
      logic valid;
      logic hi;     // upper half of the history operand
      logic first;  // first term of a section: restart the sum
      logic neg;    // term is subtracted
      logic last;   // last term of a section
   } mac_op_type;

   // Coefficients in units of 1/10000: b0, a1, a2 per row
   localparam int COEF_TENK [ROM_ROWS][3] = '{
      '{249, -19410, 9503},
      '{315, -19345, 9411},
      '{199, -19878, 9905},
      '{227, -19692, 9804},
      '{378, -19680, 9711},
      '{351, -19478, 9521}
   };

   function automatic int coef_tenk(int row, coef_sel_type sel);
      int v;
      v = 0;
      unique case (sel)
         COEF_B0: v = COEF_TENK[row][0];
         COEF_B2: v = -COEF_TENK[row][0];
         COEF_A1: v = COEF_TENK[row][1];
         COEF_A2: v = COEF_TENK[row][2];
      endcase
      return v;
   endfunction

   // Scale to 2^cfrac, round half away from zero
   function automatic longint coef_fixed(int tenk, int cfrac);
      longint mag;
      longint r;
      mag = (tenk < 0) ? -longint'(tenk) : longint'(tenk);
      r   = (mag * (longint'(1) << cfrac) + 64'sd5000) / 64'sd10000;
      return (tenk < 0) ? -r : r;
   endfunction

endpackage

### src/cbb_history.sv
// ----------------------------------------------------------------------------
// cbb_history: per-section delay storage
// Holds x1, x2, y1, y2 of every section. One read index, one write index;
// a write updates all four delays of one section at once.
// ----------------------------------------------------------------------------
module cbb_history
   import cbb_pkg::*;
#(
   parameter int SECTIONS     = SECTIONS_DEF,
   parameter int HISTORY_BITS = HISTORY_BITS_DEF,
   localparam int SEC_W       = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [SEC_W-1:0]               rd_idx,
   output logic signed [HISTORY_BITS-1:0] rd_x1,
   output logic signed [HISTORY_BITS-1:0] rd_x2,
   output logic signed [HISTORY_BITS-1:0] rd_y1,
   output logic signed [HISTORY_BITS-1:0] rd_y2,
   input  logic                           wr_en,
   input  logic [SEC_W-1:0]               wr_idx,
   input  logic signed [HISTORY_BITS-1:0] wr_x1,
   input  logic signed [HISTORY_BITS-1:0] wr_x2,
   input  logic signed [HISTORY_BITS-1:0] wr_y1,
   input  logic signed [HISTORY_BITS-1:0] wr_y2
);

   logic signed [HISTORY_BITS-1:0] x1_ff [SECTIONS];
   logic signed [HISTORY_BITS-1:0] x2_ff [SECTIONS];
   logic signed [HISTORY_BITS-1:0] y1_ff [SECTIONS];
   logic signed [HISTORY_BITS-1:0] y2_ff [SECTIONS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SECTIONS; i++) begin
            x1_ff[i] <= '0;
            x2_ff[i] <= '0;
            y1_ff[i] <= '0;
            y2_ff[i] <= '0;
         end
      end else if (wr_en) begin
         x1_ff[wr_idx] <= wr_x1;
         x2_ff[wr_idx] <= wr_x2;
         y1_ff[wr_idx] <= wr_y1;
         y2_ff[wr_idx] <= wr_y2;
      end
   end

   assign rd_x1 = x1_ff[rd_idx];
   assign rd_x2 = x2_ff[rd_idx];
   assign rd_y1 = y1_ff[rd_idx];
   assign rd_y2 = y2_ff[rd_idx];

endmodule

### src/cbb_mac.sv
// ----------------------------------------------------------------------------
// cbb_mac: shared multiply-accumulate unit
// Three-stage pipe: coefficient times one half of a history word, exact
// product assembly, then floor to history format and add/subtract into the
// section sum. done pulses when the last term of a section has landed.
// ----------------------------------------------------------------------------
module cbb_mac
   import cbb_pkg::*;
#(
   parameter int COEF_BITS    = COEF_BITS_DEF,
   parameter int HISTORY_BITS = HISTORY_BITS_DEF,
   localparam int SUM_W       = HISTORY_BITS + 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mac_op_type                     op,
   input  logic signed [COEF_BITS-1:0]    coef,
   input  logic signed [HISTORY_BITS-1:0] hist,
   output logic signed [SUM_W-1:0]        sum,
   output logic                           done
);

   localparam int LO_W   = HISTORY_BITS / 2;
   localparam int HI_W   = HISTORY_BITS - LO_W;
   localparam int OP_W   = HI_W + 1;
   localparam int PROD_W = COEF_BITS + OP_W;
   localparam int TERM_W = COEF_BITS + HISTORY_BITS;
   localparam int CFRAC  = COEF_BITS - 2;

   logic signed [OP_W-1:0]   half_op;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [TERM_W-1:0] prod_ext;
   logic signed [TERM_W-1:0] term_in;
   logic signed [TERM_W-1:0] term_ff;
   logic signed [TERM_W-1:0] term_shr;
   logic signed [SUM_W-1:0]  scaled;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  sum_ff;
   mac_op_type               tag1_ff;
   mac_op_type               tag2_ff;
   logic                     done_ff;

   // low half is unsigned, high half carries the sign
   assign half_op = op.hi ? {hist[HISTORY_BITS-1], hist[HISTORY_BITS-1:LO_W]}
                          : {{(OP_W-LO_W){1'b0}}, hist[LO_W-1:0]};
   assign prod_in = coef * half_op;

   assign prod_ext = TERM_W'(prod_ff);
   assign term_in  = tag1_ff.hi ? term_ff + (prod_ext <<< LO_W) : prod_ext;

   // floor of the exact product to history format
   assign term_shr = term_ff >>> CFRAC;
   assign scaled   = SUM_W'(term_shr);

   always_comb begin
      sum_in = sum_ff;
      if (tag2_ff.valid && tag2_ff.hi) begin
         priority if (tag2_ff.first && tag2_ff.neg) sum_in = -scaled;
         else if (tag2_ff.first)                    sum_in = scaled;
         else if (tag2_ff.neg)                      sum_in = sum_ff - scaled;
         else                                       sum_in = sum_ff + scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         tag1_ff <= op;
         tag2_ff <= tag1_ff;
         done_ff <= tag2_ff.valid && tag2_ff.hi && tag2_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (tag1_ff.valid) begin
         term_ff <= term_in;
      end
      sum_ff <= sum_in;
   end

   assign sum  = sum_ff;
   assign done = done_ff;

endmodule

### src/cascaded_biquad_bandpass.sv
// ----------------------------------------------------------------------------
// cascaded_biquad_bandpass: six-section band-pass filter, stereo in, mono out
// Averages a stereo sample pair and runs it through a cascade of direct-form-I
// biquad sections on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// req_stall is high from the acceptance of an item until its result is
// loaded into the output register, which is when it is offered. Each
// section costs four products, and each product passes the single
// multiplier twice, once per half of the history word; the next section's
// history terms issue while the previous section's sum still drains, so the
// multiplier runs every cycle of a section. A finished result waits in the
// output register, and a new item is accepted while it waits. Coefficients
// are Q2.(COEF_BITS-2); history is Q16.(HISTORY_BITS-16), saturated per
// section. The 16-bit result is the last section's output truncated toward
// zero. All section delays clear at reset.
// ----------------------------------------------------------------------------
module cascaded_biquad_bandpass
   import cbb_pkg::*;
#(
   parameter int SECTIONS     = SECTIONS_DEF,
   parameter int COEF_BITS    = COEF_BITS_DEF,
   parameter int HISTORY_BITS = HISTORY_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_left_sample,
   input  logic signed [SAMPLE_W-1:0] req_right_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_filtered_sample
);

   localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int SUM_W = HISTORY_BITS + 4;
   localparam int HFRAC = HISTORY_BITS - SAMPLE_W;
   localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(SECTIONS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROM_ROWS - 1);

   // Sequencer state
   state_type                      state_ff, state_in;
   term_type                       term_ff, term_in;
   logic                           half_ff, half_in;
   logic [SEC_W-1:0]               sec_ff, sec_in;
   logic [ROW_W-1:0]               row_ff, row_in;

   // Datapath registers
   logic signed [HISTORY_BITS-1:0] x_ff, x_in;        // current section input
   logic signed [HISTORY_BITS-1:0] wb_x1_ff, wb_x1_in;
   logic signed [HISTORY_BITS-1:0] wb_y1_ff, wb_y1_in;
   logic [SEC_W-1:0]               wb_idx_ff, wb_idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]     rsp_sample_ff, rsp_sample_in;

   // Constant coefficient table, folded at elaboration
   logic signed [COEF_BITS-1:0]    coef_rom [ROM_ROWS][COEF_SELS];
   coef_sel_type                   coef_sel;

   // History and MAC hookup
   logic signed [HISTORY_BITS-1:0] hist_x1, hist_x2, hist_y1, hist_y2;
   mac_op_type                     mac_op;
   logic signed [HISTORY_BITS-1:0] mac_hist;
   logic signed [SUM_W-1:0]        mac_sum;
   logic                           mac_done;

   logic signed [HISTORY_BITS-1:0] y_sat;
   logic signed [SAMPLE_W:0]       pair_sum;
   logic signed [SAMPLE_W:0]       pair_adj;
   logic signed [HISTORY_BITS-1:0] x_from_req;
   logic signed [SAMPLE_W-1:0]     out_sample;

   for (genvar r = 0; r < ROM_ROWS; r++) begin : g_row
      for (genvar c = 0; c < COEF_SELS; c++) begin : g_sel
         assign coef_rom[r][c] =
            COEF_BITS'(coef_fixed(coef_tenk(r, coef_sel_type'(c)), COEF_BITS - 2));
      end
   end

   cbb_history #(
      .SECTIONS     (SECTIONS),
      .HISTORY_BITS (HISTORY_BITS)
   ) u_history (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (sec_ff),
      .rd_x1  (hist_x1),
      .rd_x2  (hist_x2),
      .rd_y1  (hist_y1),
      .rd_y2  (hist_y2),
      .wr_en  (mac_done),
      .wr_idx (wb_idx_ff),
      .wr_x1  (x_ff),
      .wr_x2  (wb_x1_ff),
      .wr_y1  (y_sat),
      .wr_y2  (wb_y1_ff)
   );

   cbb_mac #(
      .COEF_BITS    (COEF_BITS),
      .HISTORY_BITS (HISTORY_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .coef  (coef_rom[row_ff][coef_sel]),
      .hist  (mac_hist),
      .sum   (mac_sum),
      .done  (mac_done)
   );

   // Stereo average, truncated toward zero: bump every negative sum by one before halving
   assign pair_sum   = {req_left_sample[SAMPLE_W-1], req_left_sample}
                     + {req_right_sample[SAMPLE_W-1], req_right_sample};
   assign pair_adj   = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};
   assign x_from_req = {pair_adj[SAMPLE_W:1], {HFRAC{1'b0}}};

   // Section output saturates to the history range
   always_comb begin
      if ((&mac_sum[SUM_W-1:HISTORY_BITS-1]) || !(|mac_sum[SUM_W-1:HISTORY_BITS-1])) begin
         y_sat = mac_sum[HISTORY_BITS-1:0];
      end else if (mac_sum[SUM_W-1]) begin
         y_sat = {1'b1, {(HISTORY_BITS-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(HISTORY_BITS-1){1'b1}}};
      end
   end

   // Integer part toward zero; the history range already fits 16 bits
   assign out_sample = x_ff[HISTORY_BITS-1:HFRAC]
                     + {{(SAMPLE_W-1){1'b0}}, x_ff[HISTORY_BITS-1] && (|x_ff[HFRAC-1:0])};

   always_comb begin
      state_in      = state_ff;
      term_in       = term_ff;
      half_in       = half_ff;
      sec_in        = sec_ff;
      row_in        = row_ff;
      x_in          = x_ff;
      wb_x1_in      = wb_x1_ff;
      wb_y1_in      = wb_y1_ff;
      wb_idx_in     = wb_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      mac_op        = '0;
      coef_sel      = COEF_B0;
      mac_hist      = x_ff;

      // finished section: its output feeds the next section
      if (mac_done) begin
         x_in = y_sat;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
               term_in  = TERM_X2;
               half_in  = 1'b0;
               sec_in   = '0;
               row_in   = '0;
               x_in     = x_from_req;
            end
         end

         ST_RUN: begin
            // history terms first, so they can issue while the previous sum drains
            mac_op.valid = 1'b1;
            mac_op.hi    = half_ff;
            mac_op.first = (term_ff == TERM_X2);
            mac_op.neg   = (term_ff == TERM_Y1) || (term_ff == TERM_Y2);
            mac_op.last  = (term_ff == TERM_X);
            unique case (term_ff)
               TERM_X2: begin
                  coef_sel = COEF_B2;
                  mac_hist = hist_x2;
               end
               TERM_Y1: begin
                  coef_sel = COEF_A1;
                  mac_hist = hist_y1;
               end
               TERM_Y2: begin
                  coef_sel = COEF_A2;
                  mac_hist = hist_y2;
               end
               TERM_X: begin
                  coef_sel = COEF_B0;
                  mac_hist = x_ff;
               end
            endcase

            half_in = !half_ff;
            if (half_ff) begin
               unique case (term_ff)
                  TERM_X2: term_in = TERM_Y1;
                  TERM_Y1: term_in = TERM_Y2;
                  TERM_Y2: term_in = TERM_X;
                  TERM_X: begin
                     term_in   = TERM_X2;
                     // delays to shift at write-back of this section
                     wb_x1_in  = hist_x1;
                     wb_y1_in  = hist_y1;
                     wb_idx_in = sec_ff;
                     if (sec_ff == LAST_SEC) begin
                        state_in = ST_DRAIN;
                     end else begin
                        sec_in = sec_ff + 1'b1;
                        row_in = (row_ff == LAST_ROW) ? '0 : row_ff + 1'b1;
                     end
                  end
               endcase
            end
         end

         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_DELIVER;
            end
         end

         ST_DELIVER: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = out_sample;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= TERM_X2;
         half_ff      <= 1'b0;
         sec_ff       <= '0;
         row_ff       <= '0;
         wb_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         half_ff      <= half_in;
         sec_ff       <= sec_in;
         row_ff       <= row_in;
         wb_idx_ff    <= wb_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      wb_x1_ff      <= wb_x1_in;
      wb_y1_ff      <= wb_y1_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_sample_ff;

`ifndef SYNTHESIS
   // a section can only complete while a sample is in flight
   a_done_in_flight: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == ST_RUN || state_ff == ST_DRAIN))
      else $error("section completed with no sample in flight");

   // the drain ends on the write-back of the final section
   a_drain_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && mac_done) |-> (wb_idx_ff == LAST_SEC))
      else $error("drain finished on a section other than the last");

   // coefficient row tracks the section index within the table
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (row_ff <= LAST_ROW && sec_ff <= LAST_SEC))
      else $error("section or coefficient row out of range");

   // a new item starts from the first term of section zero
   a_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=>
         (state_ff == ST_RUN && sec_ff == '0 && row_ff == '0 && term_ff == TERM_X2 && !half_ff))
      else $error("item did not start at the first section");
`endif

endmodule
